### src/spectrum512_pixel_group_decode_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pixel group decoder
// Shared property shapes, all clocked on clk and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef SPECTRUM512_PIXEL_GROUP_DECODE_MACROS_SVH
`define SPECTRUM512_PIXEL_GROUP_DECODE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/spc_pkg.sv
// ----------------------------------------------------------------------------
// spc_pkg
// Types, constants and helper functions shared by the pixel group decoder.
// ----------------------------------------------------------------------------
package spc_pkg;

  // Pixels carried by one decode request.
  localparam int GROUP_PIXELS = 16;
  localparam int LANE_W       = $clog2(GROUP_PIXELS);

  // Field widths of the stream.
  localparam int IDX_W    = 6;
  localparam int RAW_W    = 16;
  localparam int COL_W    = 5;
  localparam int PLANE_W  = 16;
  localparam int COLOR_W  = 4;
  localparam int XPOS_W   = COL_W + LANE_W;
  localparam int ENTRY_W  = 9;
  localparam int PIXEL_W  = 16;
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 16;

  // Window arithmetic: x1 = 10c - 5 (odd c) or 10c + 1 (even c).
  localparam int CALC_W      = 10;
  localparam int WINDOW_W    = 160;
  localparam int X1_ODD_OFS  = 5;
  localparam int X1_EVEN_OFS = 1;

  // Mode codes carried on tuser.
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  // Request held between the input stage and the serialiser.
  typedef struct packed {
    logic                                  is_decode;
    logic [IDX_W-1:0]                      wr_index;
    logic [ENTRY_W-1:0]                    wr_value;
    logic [GROUP_PIXELS-1:0][IDX_W-1:0]    idx;
  } spc_slot_t;

  // Pack a raw palette word into red, green and blue 3-bit fields.
  function automatic logic [ENTRY_W-1:0] pal_pack(input logic [RAW_W-1:0] v);
    pal_pack = {v[10:8], v[6:4], v[2:0]};
  endfunction

  // Expand a stored entry into the 16-bit output pixel layout.
  function automatic logic [PIXEL_W-1:0] pal_rgb16(input logic [ENTRY_W-1:0] e);
    pal_rgb16 = {e[8:6], 2'b00, e[5:3], 3'b000, e[2:0], 2'b00};
  endfunction

endpackage

### src/spc_ram.sv
// ----------------------------------------------------------------------------
// spc_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module spc_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // A read in the same cycle as a write to the same address returns old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/spc_lane.sv
// ----------------------------------------------------------------------------
// spc_lane
// One pixel lane: picks the palette entry for a colour at a line position.
// ----------------------------------------------------------------------------
module spc_lane
  import spc_pkg::*;
(
  input  logic [COLOR_W-1:0] color,
  input  logic [XPOS_W-1:0]  xpos,
  output logic [IDX_W-1:0]   entry
);

  logic [CALC_W-1:0] ten_c;
  logic [CALC_W-1:0] x1;
  logic [CALC_W-1:0] x2;
  logic [CALC_W-1:0] xw;

  // Ten times the colour as a shift-and-add, then the window edges.
  always_comb begin
    ten_c = CALC_W'({color, 3'b000}) + CALC_W'({color, 1'b0});
    if (color[0]) begin
      x1 = ten_c - CALC_W'(X1_ODD_OFS);
    end else begin
      x1 = ten_c + CALC_W'(X1_EVEN_OFS);
    end
    x2 = x1 + CALC_W'(WINDOW_W);
    xw = CALC_W'(xpos);
  end

  // Third window selects c+32, the middle one c+16, otherwise c itself.
  always_comb begin
    if (xw >= x2) begin
      entry = {2'b10, color};
    end else if (xw >= x1) begin
      entry = {2'b01, color};
    end else begin
      entry = {2'b00, color};
    end
  end

endmodule

### src/spc_merge.sv
// ----------------------------------------------------------------------------
// spc_merge
// Serialises the lane results through the palette RAM into the pixel stream.
// ----------------------------------------------------------------------------
module spc_merge
  import spc_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 48
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  slot_v,
  input  spc_slot_t             slot,
  output logic                  take,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast
);

  localparam int AW = $clog2(PALETTE_ENTRIES);

  logic                               act_v_r;
  logic [GROUP_PIXELS-1:0][IDX_W-1:0] act_idx_r;
  logic [LANE_W-1:0]                  cnt_r;
  logic                               rd_v_r;
  logic                               rd_last_r;
  logic                               out_v_r;
  logic [PIXEL_W-1:0]                 out_data_r;
  logic                               out_last_r;

  logic               out_free;
  logic               rd_free;
  logic               issue;
  logic               act_done;
  logic               we;
  logic [ENTRY_W-1:0] rdata;

  // Flow control: a read is issued only when its data has somewhere to go.
  always_comb begin
    out_free = !out_v_r || out_tready;
    rd_free  = !rd_v_r || out_free;
    issue    = act_v_r && rd_free;
    act_done = issue && (&cnt_r);
    take     = slot_v && (!act_v_r || act_done);
    we       = take && !slot.is_decode && (slot.wr_index < IDX_W'(PALETTE_ENTRIES));
  end

  // Palette store; loads land only once earlier groups have issued all reads.
  spc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk   (clk),
    .we    (we),
    .waddr (AW'(slot.wr_index)),
    .wdata (slot.wr_value),
    .re    (issue),
    .raddr (AW'(act_idx_r[cnt_r])),
    .rdata (rdata)
  );

  // Active group, pixel counter and the read and output stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_v_r <= 1'b0;
      cnt_r   <= '0;
      rd_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (take) begin
        act_v_r <= slot.is_decode;
        cnt_r   <= '0;
      end else begin
        if (act_done) begin
          act_v_r <= 1'b0;
        end
        if (issue) begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
      if (issue) begin
        rd_v_r <= 1'b1;
      end else if (out_free) begin
        rd_v_r <= 1'b0;
      end
      if (out_free) begin
        out_v_r <= rd_v_r;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (take) begin
      act_idx_r <= slot.idx;
    end
    if (issue) begin
      rd_last_r <= &cnt_r;
    end
    if (out_free && rd_v_r) begin
      out_data_r <= pal_rgb16(rdata);
      out_last_r <= rd_last_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

### src/spectrum512_pixel_group_decode.sv
// Path: a taken request passes the holding slot, the active group register, the palette
// RAM read register and the output register. Throughput: one pixel per cycle while the
// output is not stalled. The single read port of the palette RAM sets this figure.
// Reset: synchronous, active low; clears handshake and sequencing state only.
// The palette holds no reset value and must be loaded before it is read.
// ----------------------------------------------------------------------------
// spectrum512_pixel_group_decode
// Decodes 16-pixel bitplane groups of a palette-switching raster line.
// ----------------------------------------------------------------------------
`include "spectrum512_pixel_group_decode_macros.svh"

module spectrum512_pixel_group_decode
  import spc_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 48
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // tdata from bit 0: entry_index[5:0], entry_value[21:6], group_column[26:22],
  // plane0_word[42:27], plane1_word[58:43], plane2_word[74:59],
  // plane3_word[90:75], zero fill[95:91]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // tuser: mode (0 load palette entry, 1 decode group)
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // tdata: pixel_color[15:0]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // tlast: last_pixel
  output logic                  out_tlast
);

  logic [IDX_W-1:0]   f_index;
  logic [RAW_W-1:0]   f_value;
  logic [COL_W-1:0]   f_col;
  logic [PLANE_W-1:0] f_p0;
  logic [PLANE_W-1:0] f_p1;
  logic [PLANE_W-1:0] f_p2;
  logic [PLANE_W-1:0] f_p3;

  logic                               slot_v_r;
  spc_slot_t                          slot_r;
  spc_slot_t                          slot_nxt;
  logic                               take;
  logic                               in_req;
  logic [GROUP_PIXELS-1:0][IDX_W-1:0] lane_entry;

  // Unpack the request.
  assign f_index = in_tdata[5:0];
  assign f_value = in_tdata[21:6];
  assign f_col   = in_tdata[26:22];
  assign f_p0    = in_tdata[42:27];
  assign f_p1    = in_tdata[58:43];
  assign f_p2    = in_tdata[74:59];
  assign f_p3    = in_tdata[90:75];

  // One lane per pixel; bit 15 of each plane is the leftmost pixel.
  for (genvar t = 0; t < GROUP_PIXELS; t++) begin : g_lane
    localparam int BIT = GROUP_PIXELS - 1 - t;
    spc_lane u_lane (
      .color ({f_p3[BIT], f_p2[BIT], f_p1[BIT], f_p0[BIT]}),
      .xpos  ({f_col, LANE_W'(t)}),
      .entry (lane_entry[t])
    );
  end

  // The holding slot frees as the serialiser takes it.
  assign in_tready = !slot_v_r || take;
  assign in_req    = in_tvalid && in_tready;

  always_comb begin
    slot_nxt.is_decode = (in_tuser == MODE_DECODE);
    slot_nxt.wr_index  = f_index;
    slot_nxt.wr_value  = pal_pack(f_value);
    slot_nxt.idx       = lane_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_v_r <= 1'b0;
    end else if (in_req) begin
      slot_v_r <= 1'b1;
    end else if (take) begin
      slot_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_req) begin
      slot_r <= slot_nxt;
    end
  end

  // Palette RAM, pixel sequencing and the output register.
  spc_merge #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .slot_v     (slot_v_r),
    .slot       (slot_r),
    .take       (take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // Checks on the holding slot.
  `SPC_ASSERT_SAME(a_take_needs_slot, take, slot_v_r, "slot taken while empty")
  `SPC_ASSERT_NEXT(a_req_fills_slot, in_req, slot_v_r, "accepted request not held")
  `SPC_ASSERT_NEXT(a_slot_holds, slot_v_r && !take, slot_v_r && $stable(slot_r), "slot lost")

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pixel group decoder. A queue of load and decode
// requests feeds a clocked driver; a clocked monitor checks every pixel against
// a local palette model in order. The run passes through four pacing phases and
// one long output hold-off.
// ----------------------------------------------------------------------------
module tb;
  import spc_pkg::*;

  localparam int PALETTE_SIZE = 48;
  localparam int LINE_COLS    = 20;
  localparam int LINES        = 6;
  localparam int NOISE_ITEMS  = 6;
  localparam int HOLD_AT      = 100;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 300000;

  // One request as the sender sees it.
  typedef struct packed {
    logic               mode;
    logic [IDX_W-1:0]   idx;
    logic [RAW_W-1:0]   raw;
    logic [COL_W-1:0]   col;
    logic [3:0][15:0]   planes;
  } raster_req_t;

  // One expected output pixel.
  typedef struct packed {
    logic [PIXEL_W-1:0] colour;
    logic               last;
  } pixel_t;

  // Pacing phases, chosen from how many requests have been taken.
  typedef enum int {PACE_FREE, PACE_SENDER_SLOW, PACE_RECEIVER_SLOW, PACE_BOTH_LIGHT} pace_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;

  raster_req_t  pending_reqs[$];
  raster_req_t  on_bus;
  pixel_t       pixel_q[$];
  logic [8:0]   palette_shadow[PALETTE_SIZE];
  int unsigned  taken_count = 0;
  int unsigned  total_reqs = 0;
  int unsigned  phase_len = 1;
  int unsigned  fail_count = 0;
  int unsigned  hold_left = 0;
  bit           hold_done = 1'b0;
  int unsigned  cycle_count = 0;

  spectrum512_pixel_group_decode dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Pacing helpers: the current phase and a weighted coin.
  function automatic pace_t current_pace();
    int unsigned ph;
    ph = taken_count / phase_len;
    if (ph >= 3) return PACE_BOTH_LIGHT;
    return pace_t'(ph);
  endfunction

  function automatic bit coin(input int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic bit sender_rests();
    pace_t p;
    p = current_pace();
    if (p == PACE_SENDER_SLOW) return coin(87);
    if (p == PACE_BOTH_LIGHT) return coin(13);
    return 1'b0;
  endfunction

  function automatic bit receiver_rests();
    pace_t p;
    p = current_pace();
    if (p == PACE_RECEIVER_SLOW) return coin(87);
    if (p == PACE_BOTH_LIGHT) return coin(13);
    return 1'b0;
  endfunction

  // Palette model: loads update the shadow, decodes queue sixteen pixels.
  task automatic apply_request(input raster_req_t r);
    int x;
    int x1;
    int c;
    int sel;
    int t;
    logic [8:0] e;
    pixel_t px;
    if (r.mode == MODE_LOAD) begin
      if (r.idx < PALETTE_SIZE)
        palette_shadow[r.idx] = {r.raw[10:8], r.raw[6:4], r.raw[2:0]};
    end else begin
      for (t = 0; t < GROUP_PIXELS; t++) begin
        c = {r.planes[3][15-t], r.planes[2][15-t], r.planes[1][15-t], r.planes[0][15-t]};
        x = r.col * GROUP_PIXELS + t;
        x1 = (c % 2 == 1) ? 10 * c - 5 : 10 * c + 1;
        // Three windows along the line pick the low, middle or high bank.
        if (x >= x1 + 160) sel = c + 32;
        else if (x >= x1) sel = c + 16;
        else sel = c;
        e = palette_shadow[sel];
        px.colour = (16'(e[8:6]) << 13) | (16'(e[5:3]) << 8) | (16'(e[2:0]) << 2);
        px.last = (t == GROUP_PIXELS - 1);
        pixel_q.push_back(px);
      end
    end
  endtask

  task automatic flag_failure(input string what, input pixel_t want, input pixel_t got);
    if (fail_count < 10)
      $display("%s: expected colour %h last %b, got colour %h last %b",
               what, want.colour, want.last, got.colour, got.last);
    fail_count++;
  endtask

  task automatic push_load(input int unsigned idx, input logic [15:0] raw);
    raster_req_t r;
    r = '0;
    r.mode = MODE_LOAD;
    r.idx = idx[IDX_W-1:0];
    r.raw = raw;
    pending_reqs.push_back(r);
  endtask

  task automatic push_decode(input int unsigned col, input logic [15:0] p0,
                             input logic [15:0] p1, input logic [15:0] p2,
                             input logic [15:0] p3);
    raster_req_t r;
    r = '0;
    r.mode = MODE_DECODE;
    r.col = col[COL_W-1:0];
    r.planes = {p3, p2, p1, p0};
    pending_reqs.push_back(r);
  endtask

  // Driver: presents queued requests and predicts each one as it is taken.
  always @(posedge clk) begin : driver
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tuser <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        apply_request(on_bus);
        taken_count <= taken_count + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_reqs.size() != 0 && !sender_rests()) begin
          on_bus = pending_reqs.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {5'b0, on_bus.planes[3], on_bus.planes[2], on_bus.planes[1],
                       on_bus.planes[0], on_bus.col, on_bus.raw, on_bus.idx};
          in_tuser <= on_bus.mode;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // One long output hold-off so that the block fills and stalls its input.
  always @(posedge clk) begin : hold_off
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && taken_count >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: compares each pixel with the oldest expectation.
  always @(posedge clk) begin : monitor
    pixel_t want;
    pixel_t got;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.colour = out_tdata;
        got.last = out_tlast;
        if (pixel_q.size() == 0) begin
          flag_failure("unexpected pixel", '0, got);
        end else begin
          want = pixel_q.pop_front();
          if (got.colour !== want.colour || got.last !== want.last)
            flag_failure("pixel mismatch", want, got);
        end
      end
      out_tready <= (hold_left == 0) && !receiver_rests();
    end
  end

  // Watchdog.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // Stimulus, reset and end of run.
  initial begin : stimulus
    int order[PALETTE_SIZE];
    int i;
    int j;
    int k;
    int tmp;
    int ln;

    // Fill the whole palette first so that no decode reads an unwritten entry.
    for (i = 0; i < PALETTE_SIZE; i++) begin
      if (i == 0) push_load(i, 16'hFFFF);
      else if (i == PALETTE_SIZE - 1) push_load(i, 16'h0000);
      else push_load(i, 16'($urandom));
    end

    // Directed: ignored loads beyond the palette, line ends, colour ramps.
    push_load(48, 16'hFFFF);
    push_load(63, 16'hAAAA);
    push_decode(0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    push_decode(0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_decode(19, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    push_decode(19, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_decode(0, 16'h5555, 16'h3333, 16'h0F0F, 16'h00FF);
    push_decode(5, 16'h5555, 16'h3333, 16'h0F0F, 16'h00FF);
    push_decode(9, 16'h5555, 16'h3333, 16'h0F0F, 16'h00FF);
    push_decode(10, 16'h5555, 16'h3333, 16'h0F0F, 16'h00FF);
    push_decode(15, 16'h5555, 16'h3333, 16'h0F0F, 16'h00FF);
    push_decode(19, 16'hAAAA, 16'hCCCC, 16'hF0F0, 16'hFF00);
    // Columns past the line end all land in the high bank.
    push_decode(20, 16'h5555, 16'h3333, 16'h0F0F, 16'h00FF);
    push_decode(31, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_load(16, 16'hF888);
    push_decode(5, 16'h5555, 16'h3333, 16'h0F0F, 16'h00FF);

    // Random lines: a shuffled palette reload, then the twenty groups in order,
    // followed by a few stray loads and decodes.
    for (ln = 0; ln < LINES; ln++) begin
      for (i = 0; i < PALETTE_SIZE; i++) order[i] = i;
      for (i = PALETTE_SIZE - 1; i > 0; i--) begin
        j = $urandom_range(i);
        tmp = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
      for (i = 0; i < PALETTE_SIZE; i++) push_load(order[i], 16'($urandom));
      for (i = 0; i < LINE_COLS; i++)
        push_decode(i, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      for (k = 0; k < NOISE_ITEMS; k++) begin
        if (coin(50))
          push_load($urandom_range(63), 16'($urandom));
        else
          push_decode($urandom_range(31), 16'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom));
      end
    end

    total_reqs = pending_reqs.size();
    phase_len = total_reqs / 4;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (taken_count < total_reqs) @(posedge clk);
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    while (pixel_q.size() != 0)
      flag_failure("missing pixel", pixel_q.pop_front(), '0);

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
